// ===== rtl/lcuc_pkg.sv =====
`default_nettype none
package lcuc_pkg;

  localparam int LCUC_QUEUE_DEPTH = 4;

  // Projection divider: 32 quotient bits, one a stage, after a setup stage
  localparam int PROJ_QBITS   = 32;
  localparam int PROJ_DIV_LAT = PROJ_QBITS + 1;

  // Clip fraction divider: 17 quotient bits (0..65536 plus an overflow marker)
  localparam int CLIP_QBITS   = 17;
  localparam int CLIP_DIV_LAT = CLIP_QBITS + 1;

  localparam int NUM_PLANES = 6;
  localparam int NUM_STEPS  = 2 * NUM_PLANES;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

  // Planes in clip order: left, right, top, bottom, back, front
  localparam logic [NUM_PLANES-1:0][1:0] PLANE_AXIS =
    {2'd2, 2'd2, 2'd1, 2'd1, 2'd0, 2'd0};
  localparam logic [NUM_PLANES-1:0] PLANE_NEG = 6'b011001;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic signed [31:0] first_w;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic signed [31:0] second_w;
    logic [31:0]        first_rgba;
    logic [31:0]        second_rgba;
  } in_t;

  typedef struct packed {
    logic               accepted;
    logic signed [31:0] out_first_x;
    logic signed [31:0] out_first_y;
    logic signed [31:0] out_first_z;
    logic signed [31:0] out_first_w;
    logic signed [31:0] out_second_x;
    logic signed [31:0] out_second_y;
    logic signed [31:0] out_second_z;
    logic signed [31:0] out_second_w;
    logic [31:0]        out_first_rgba;
    logic [31:0]        out_second_rgba;
  } out_t;

  // Original vertices and colours, carried alongside the arithmetic
  typedef struct packed {
    logic             zero_w;
    logic [3:0][31:0] v1;
    logic [3:0][31:0] v2;
    logic [31:0]      c1;
    logic [31:0]      c2;
  } vtx_t;

  typedef struct packed {
    vtx_t             side;
    logic [2:0][31:0] p1;
    logic [2:0][31:0] p2;
  } item_t;

  typedef struct packed {
    logic                           rej;
    logic [16:0]                    u1;
    logic [16:0]                    u2;
    logic                           m1;
    logic                           m2;
    logic [NUM_STEPS-1:0][17:0]     q;
    item_t                          item;
  } step_t;

  // Distance outside a plane: s*p - 1.0, positive means outside
  function automatic logic signed [33:0] plane_excess(input logic [31:0] p,
                                                      input logic neg);
    logic signed [33:0] ps;
    ps = 34'(signed'(p));
    return (neg ? -ps : ps) - 34'sd65536;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/lcuc_proj_div.sv =====
`default_nettype none
module lcuc_proj_div import lcuc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [31:0] num,
  input  wire logic signed [31:0] den,
  output logic signed [31:0]      quo
);

  localparam int QB = PROJ_QBITS;

  logic [31:0] absn, absd;
  logic        ovf_in;

  logic [32:0] r_r   [0:QB-1];
  logic [31:0] d_r   [0:QB-1];
  logic [15:0] lo_r  [0:QB-1];
  logic [31:0] q_r   [0:QB];
  logic        neg_r [0:QB];
  logic        ovf_r [0:QB];

  assign absn   = num[31] ? (~num + 32'd1) : num;
  assign absd   = den[31] ? (~den + 32'd1) : den;
  // Quotient of (|num| << 16) / |den| needs more than 32 bits
  assign ovf_in = {16'd0, absn} >= {absd, 16'd0};

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]   <= {17'd0, absn[31:16]};
      d_r[0]   <= absd;
      lo_r[0]  <= absn[15:0];
      q_r[0]   <= '0;
      neg_r[0] <= num[31] ^ den[31];
      ovf_r[0] <= ovf_in;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_stage
    logic [32:0] rt, rn;
    logic        b;
    assign rt = {r_r[j-1][31:0], lo_r[j-1][15]};
    assign b  = rt >= {1'b0, d_r[j-1]};
    assign rn = b ? (rt - {1'b0, d_r[j-1]}) : rt;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]   <= {q_r[j-1][30:0], b};
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end

    if (j < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[j]  <= rn;
          d_r[j]  <= d_r[j-1];
          lo_r[j] <= {lo_r[j-1][14:0], 1'b0};
        end
      end
    end
  end

  // Apply sign, saturate to the signed 32-bit range
  always_comb begin
    if (neg_r[QB]) begin
      if (ovf_r[QB] || (q_r[QB] > 32'h8000_0000)) quo = 32'sh8000_0000;
      else quo = ~q_r[QB] + 32'd1;
    end else begin
      if (ovf_r[QB] || q_r[QB][31]) quo = 32'sh7FFF_FFFF;
      else quo = q_r[QB];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lcuc_front.sv =====
`default_nettype none
module lcuc_front import lcuc_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      push,
  output item_t     push_item,
  input  wire logic q_full
);

  localparam int LAT = PROJ_DIV_LAT;

  logic             front_en;
  logic [LAT-1:0]   vld_r;
  vtx_t             sb_r [0:LAT-1];
  vtx_t             side_in;
  logic [3:0][31:0] v1_in, v2_in;
  logic [2:0][31:0] p1, p2;

  assign v1_in = {in_data.first_w, in_data.first_z, in_data.first_y, in_data.first_x};
  assign v2_in = {in_data.second_w, in_data.second_z, in_data.second_y, in_data.second_x};

  assign side_in.zero_w = (in_data.first_w == 32'sd0) || (in_data.second_w == 32'sd0);
  assign side_in.v1     = v1_in;
  assign side_in.v2     = v2_in;
  assign side_in.c1     = in_data.first_rgba;
  assign side_in.c2     = in_data.second_rgba;

  // Hold the whole front while its last transaction cannot enter the queue
  assign front_en = !(vld_r[LAT-1] && q_full);
  assign in_stall = !front_en;
  assign push     = front_en && vld_r[LAT-1];

  for (genvar i = 0; i < 3; i++) begin : g_div
    lcuc_proj_div u_div1 (
      .clk (clk),
      .en  (front_en),
      .num (v1_in[i]),
      .den (v1_in[3]),
      .quo (p1[i])
    );
    lcuc_proj_div u_div2 (
      .clk (clk),
      .en  (front_en),
      .num (v2_in[i]),
      .den (v2_in[3]),
      .quo (p2[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (front_en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (front_en) begin
      sb_r[0] <= side_in;
      for (int j = 1; j < LAT; j++) sb_r[j] <= sb_r[j-1];
    end
  end

  assign push_item.side = sb_r[LAT-1];
  assign push_item.p1   = p1;
  assign push_item.p2   = p2;

endmodule
`default_nettype wire

// ===== rtl/lcuc_queue.sv =====
`default_nettype none
module lcuc_queue import lcuc_pkg::*; #(
  parameter int DEPTH = LCUC_QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire item_t push_item,
  output logic       full,
  input  wire logic  en,
  output logic       q_vld,
  output item_t      q_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t          mem [0:DEPTH-1];
  logic [AW-1:0]  wr_r, rd_r;
  logic [CW-1:0]  cnt_r;
  logic           pop;
  logic           q_vld_r;
  item_t          q_item_r;

  assign pop   = en && (cnt_r != '0);
  assign full  = cnt_r == CW'(DEPTH);
  assign q_vld  = q_vld_r;
  assign q_item = q_item_r;

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= push_item;
    if (en) q_item_r <= mem[rd_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      cnt_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      if (push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      if (pop) rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
      if (en) q_vld_r <= pop;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lcuc_clip_div.sv =====
`default_nettype none
module lcuc_clip_div import lcuc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [33:0] e_own,
  input  wire logic signed [33:0] e_oth,
  output logic [17:0]             q
);

  localparam int QB = CLIP_QBITS;

  logic signed [34:0] den;
  logic               low_in, high_in;

  logic [34:0] r_r   [0:QB-1];
  logic [33:0] d_r   [0:QB-1];
  logic [16:0] q_r   [0:QB];
  logic        low_r [0:QB];
  logic        high_r[0:QB];

  assign den     = 35'(e_own) - 35'(e_oth);
  // Non-positive numerator: fraction clamps to the lower bound anyway
  assign low_in  = e_own[33] || (e_own == 34'sd0);
  // Quotient of one or more: clamps to the upper bound anyway
  assign high_in = !low_in && ((den <= 35'sd0) || (35'(e_own) >= den));

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0]    <= {2'b00, e_own[32:0]};
      d_r[0]    <= den[33:0];
      q_r[0]    <= '0;
      low_r[0]  <= low_in;
      high_r[0] <= high_in;
    end
  end

  for (genvar j = 1; j <= QB; j++) begin : g_stage
    logic [34:0] rn;
    logic        b;
    assign b  = r_r[j-1] >= {1'b0, d_r[j-1]};
    assign rn = b ? (r_r[j-1] - {1'b0, d_r[j-1]}) : r_r[j-1];

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[j]    <= {q_r[j-1][15:0], b};
        low_r[j]  <= low_r[j-1];
        high_r[j] <= high_r[j-1];
      end
    end

    if (j < QB) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[j] <= {rn[33:0], 1'b0};
          d_r[j] <= d_r[j-1];
        end
      end
    end
  end

  always_comb begin
    if (low_r[QB])       q = '0;
    else if (high_r[QB]) q = 18'h2_0000;
    else                 q = {1'b0, q_r[QB]};
  end

endmodule
`default_nettype wire

// ===== rtl/lcuc_back.sv =====
`default_nettype none
module lcuc_back import lcuc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_vld,
  input  wire item_t q_item,
  output logic       q_en,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_t       out_data
);

  localparam int LAT = CLIP_DIV_LAT;

  logic                       back_en;
  logic [NUM_STEPS-1:0][17:0] qdiv;
  logic [LAT-1:0]             sb_vld_r;
  item_t                      sb_r [0:LAT-1];
  logic [NUM_STEPS-1:0]       st_vld_r;
  step_t                      st_r [0:NUM_STEPS-1];
  step_t                      st_in0;
  logic                       out_vld_r;
  out_t                       out_r, out_nxt;

  function automatic step_t clip_step(input step_t s, input logic [3:0] k);
    logic [2:0]         pl;
    logic               second;
    logic signed [33:0] e1, e2, eo, et;
    logic signed [34:0] d;
    logic signed [52:0] po, pt;
    logic signed [55:0] fo, ft;
    logic [16:0]        uo, ut, hi;
    logic [17:0]        uc;
    step_t              r;
    r      = s;
    pl     = k[3:1];
    second = k[0];
    e1 = plane_excess(s.item.p1[PLANE_AXIS[pl]], PLANE_NEG[pl]);
    e2 = plane_excess(s.item.p2[PLANE_AXIS[pl]], PLANE_NEG[pl]);
    eo = second ? e2 : e1;
    et = second ? e1 : e2;
    uo = second ? s.u2 : s.u1;
    ut = second ? s.u1 : s.u2;
    d  = 35'(et) - 35'(eo);
    po = $signed({1'b0, uo}) * d;
    pt = $signed({1'b0, ut}) * d;
    // Exact plane distance of each end at its current fraction
    fo = (56'(eo) <<< 16) + 56'(po);
    ft = (56'(et) <<< 16) - 56'(pt);
    hi = 17'(ONE_Q16) - ut;
    uc = s.q[k];
    if (uc < {1'b0, uo}) uc = {1'b0, uo};
    if (uc > {1'b0, hi}) uc = {1'b0, hi};
    if (!s.rej && (fo > 56'sd0)) begin
      if ((ft >= 56'sd0) || (d >= 35'sd0)) begin
        r.rej = 1'b1;
      end else if (second) begin
        r.u2 = uc[16:0];
        r.m2 = 1'b1;
      end else begin
        r.u1 = uc[16:0];
        r.m1 = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic logic [31:0] place(input logic [31:0] own, input logic [31:0] oth,
                                        input logic [16:0] u);
    logic signed [32:0] diff;
    logic signed [50:0] prod;
    logic signed [34:0] delta;
    logic signed [35:0] v;
    diff  = 33'(signed'(oth)) - 33'(signed'(own));
    prod  = diff * $signed({1'b0, u});
    // Truncate toward zero
    delta = prod[50] ? 35'((prod + 51'sd65535) >>> 16) : 35'(prod >>> 16);
    v     = 36'(signed'(own)) + 36'(delta);
    if (v > 36'sd65536) v = 36'sd65536;
    else if (v < -36'sd65536) v = -36'sd65536;
    return v[31:0];
  endfunction

  function automatic logic [31:0] blend(input logic [31:0] own, input logic [31:0] oth,
                                        input logic [16:0] u);
    logic [31:0] res;
    logic [16:0] iu;
    logic [25:0] acc;
    res = '0;
    iu  = 17'(ONE_Q16) - u;
    for (int sh = 0; sh < 4; sh++) begin
      acc = 26'(own[sh*8 +: 8]) * 26'(iu) + 26'(oth[sh*8 +: 8]) * 26'(u);
      res[sh*8 +: 8] = acc[23:16];
    end
    return res;
  endfunction

  // Hold everything while a finished result waits to be taken
  assign back_en = !(out_vld_r && out_stall);
  assign q_en    = back_en;

  for (genvar i = 0; i < NUM_PLANES; i++) begin : g_plane
    logic signed [33:0] e1, e2;
    assign e1 = plane_excess(q_item.p1[PLANE_AXIS[i]], PLANE_NEG[i]);
    assign e2 = plane_excess(q_item.p2[PLANE_AXIS[i]], PLANE_NEG[i]);

    lcuc_clip_div u_div1 (
      .clk   (clk),
      .en    (back_en),
      .e_own (e1),
      .e_oth (e2),
      .q     (qdiv[2*i])
    );
    lcuc_clip_div u_div2 (
      .clk   (clk),
      .en    (back_en),
      .e_own (e2),
      .e_oth (e1),
      .q     (qdiv[2*i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      sb_r[0] <= q_item;
      for (int j = 1; j < LAT; j++) sb_r[j] <= sb_r[j-1];
    end
  end

  assign st_in0.rej  = sb_r[LAT-1].side.zero_w;
  assign st_in0.u1   = '0;
  assign st_in0.u2   = '0;
  assign st_in0.m1   = 1'b0;
  assign st_in0.m2   = 1'b0;
  assign st_in0.q    = qdiv;
  assign st_in0.item = sb_r[LAT-1];

  for (genvar k = 0; k < NUM_STEPS; k++) begin : g_step
    step_t sin;
    if (k == 0) begin : g_first
      assign sin = st_in0;
    end else begin : g_next
      assign sin = st_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (back_en) st_r[k] <= clip_step(sin, 4'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_vld_r  <= '0;
      st_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else if (back_en) begin
      sb_vld_r  <= {sb_vld_r[LAT-2:0], q_vld};
      st_vld_r  <= {st_vld_r[NUM_STEPS-2:0], sb_vld_r[LAT-1]};
      out_vld_r <= st_vld_r[NUM_STEPS-1];
    end
  end

  always_comb begin
    step_t s;
    s       = st_r[NUM_STEPS-1];
    out_nxt = '0;
    if (!s.rej) begin
      out_nxt.accepted        = 1'b1;
      out_nxt.out_first_x     = s.m1 ? place(s.item.p1[0], s.item.p2[0], s.u1)
                                     : s.item.side.v1[0];
      out_nxt.out_first_y     = s.m1 ? place(s.item.p1[1], s.item.p2[1], s.u1)
                                     : s.item.side.v1[1];
      out_nxt.out_first_z     = s.m1 ? place(s.item.p1[2], s.item.p2[2], s.u1)
                                     : s.item.side.v1[2];
      out_nxt.out_first_w     = s.m1 ? ONE_Q16 : s.item.side.v1[3];
      out_nxt.out_second_x    = s.m2 ? place(s.item.p2[0], s.item.p1[0], s.u2)
                                     : s.item.side.v2[0];
      out_nxt.out_second_y    = s.m2 ? place(s.item.p2[1], s.item.p1[1], s.u2)
                                     : s.item.side.v2[1];
      out_nxt.out_second_z    = s.m2 ? place(s.item.p2[2], s.item.p1[2], s.u2)
                                     : s.item.side.v2[2];
      out_nxt.out_second_w    = s.m2 ? ONE_Q16 : s.item.side.v2[3];
      out_nxt.out_first_rgba  = s.m1 ? blend(s.item.side.c1, s.item.side.c2, s.u1)
                                     : s.item.side.c1;
      out_nxt.out_second_rgba = s.m2 ? blend(s.item.side.c2, s.item.side.c1, s.u2)
                                     : s.item.side.c2;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en) out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ===== rtl/line_clip_unit_cube.sv =====
`default_nettype none
// Clips one line per clock against the unit cube, while in_stall is low. A new
// line can be accepted every cycle in which in_stall is low. Path: the front,
// where six 32-stage restoring dividers (one quotient bit a stage) project the
// vertices, the queue write and its registered read, then the back: the twelve
// clip-fraction dividers (17 quotient bits), one stage for each of the twelve
// plane tests, and the output register. A stall on the result side holds the
// back only; the front keeps taking lines until the QUEUE_DEPTH-entry queue
// fills. Rejected lines give accepted = 0 and all other fields zero.
module line_clip_unit_cube import lcuc_pkg::*; #(
  parameter int QUEUE_DEPTH = LCUC_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  logic  push, q_full, q_en, q_vld;
  item_t push_item, q_item;

  lcuc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_full    (q_full)
  );

  lcuc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .en        (q_en),
    .q_vld     (q_vld),
    .q_item    (q_item)
  );

  lcuc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_vld     (q_vld),
    .q_item    (q_item),
    .q_en      (q_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/lcuc_checker.sv =====
`default_nettype none
module lcuc_checker import lcuc_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.accepted |->
      out_data.out_first_x == 0 && out_data.out_first_y == 0 &&
      out_data.out_first_z == 0 && out_data.out_first_w == 0 &&
      out_data.out_second_x == 0 && out_data.out_second_y == 0 &&
      out_data.out_second_z == 0 && out_data.out_second_w == 0 &&
      out_data.out_first_rgba == 0 && out_data.out_second_rgba == 0)
    else $error("rejected line carries data");

  a_accept_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.accepted |->
      out_data.out_first_w != 0 && out_data.out_second_w != 0)
    else $error("accepted line with zero w");

endmodule

bind line_clip_unit_cube lcuc_checker u_lcuc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
